>>> hdl/gfbs_pkg.sv
// Package for the grouped free block stack.
// Holds operation and status codes, field widths and the controller/datapath
// command and status structs. No dependencies.
package gfbs_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam int WORD_W      = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int SPILL_IDX_W = 4;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RECLAIM = 2'd1;
   localparam logic [OP_W-1:0] OP_FILL    = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FILL = 2'd3;

   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_SPILL    = 1'b1;

   typedef struct packed {
      logic capture;
      logic execute;
      logic spill_start;
      logic spill_read;
      logic spill_load;
      logic spill_next;
      logic spill_end;
   } ctrl_cmd_type;

   typedef struct packed {
      logic spill_needed;
      logic spill_last;
   } dp_status_type;

endpackage

>>> hdl/gfbs_datapath.sv
// Datapath of the grouped free block stack: stack memory, counters and the
// result register. Depends on gfbs_pkg; driven by gfbs_controller commands.
module gfbs_datapath #(
   parameter int STACK_DEPTH = gfbs_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gfbs_pkg::ctrl_cmd_type               cmd,
   output gfbs_pkg::dp_status_type              status,
   input  logic [gfbs_pkg::OP_W-1:0]            req_operation,
   input  logic [gfbs_pkg::WORD_W-1:0]          req_freed_block,
   input  logic [gfbs_pkg::WORD_W-1:0]          req_fill_word,
   output logic                                 rsp_kind,
   output logic [gfbs_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_given_block,
   output logic                                 rsp_need_refill,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_spill_target,
   output logic [gfbs_pkg::SPILL_IDX_W-1:0]     rsp_spill_index,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_spill_value,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STACK_DEPTH - 1);

   logic [gfbs_pkg::WORD_W-1:0] stack_mem_ff [STACK_DEPTH];
   logic [gfbs_pkg::WORD_W-1:0] rd_data_ff;

   logic [gfbs_pkg::OP_W-1:0]   op_ff;
   logic [gfbs_pkg::WORD_W-1:0] freed_ff;
   logic [gfbs_pkg::WORD_W-1:0] word_ff;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [gfbs_pkg::WORD_W-1:0] final_ff, final_in;
   logic                        refilling_ff, refilling_in;
   logic [IDX_W-1:0]            fill_pos_ff, fill_pos_in;
   logic [IDX_W-1:0]            spill_cnt_ff, spill_cnt_in;

   logic                           kind_ff, kind_in;
   logic [gfbs_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [gfbs_pkg::WORD_W-1:0]    given_ff, given_in;
   logic                           need_ff, need_in;
   logic [gfbs_pkg::WORD_W-1:0]    target_ff, target_in;
   logic [gfbs_pkg::SPILL_IDX_W-1:0] index_ff, index_in;
   logic [gfbs_pkg::WORD_W-1:0]    value_ff, value_in;
   logic                           last_ff, last_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [gfbs_pkg::WORD_W-1:0] wr_data;
   logic [CNT_W-1:0]            count_dec;
   logic [IDX_W-1:0]            rd_addr;

   assign count_dec = count_ff - 1'b1;
   assign rd_addr   = cmd.spill_read ? spill_cnt_ff : count_dec[IDX_W-1:0];

   assign status.spill_needed = (op_ff == gfbs_pkg::OP_RECLAIM) && !refilling_ff &&
                                (count_ff == FULL_COUNT);
   assign status.spill_last   = (spill_cnt_ff == LAST_IDX);

   always_comb begin
      count_in     = count_ff;
      final_in     = final_ff;
      refilling_in = refilling_ff;
      fill_pos_in  = fill_pos_ff;
      spill_cnt_in = spill_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = freed_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      given_in     = given_ff;
      need_in      = need_ff;
      target_in    = target_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      if (cmd.execute || cmd.spill_end) begin
         kind_in   = gfbs_pkg::KIND_RESPONSE;
         status_in = gfbs_pkg::STATUS_OK;
         given_in  = '0;
         need_in   = 1'b0;
         target_in = '0;
         index_in  = '0;
         value_in  = '0;
         last_in   = 1'b1;
      end

      if (cmd.execute) begin
         if (refilling_ff && (op_ff != gfbs_pkg::OP_FILL)) begin
            status_in = gfbs_pkg::STATUS_BUSY;
         end else begin
            case (op_ff)
               gfbs_pkg::OP_FILL: begin
                  if (!refilling_ff) begin
                     status_in = gfbs_pkg::STATUS_BAD_FILL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = fill_pos_ff;
                     wr_data = word_ff;
                     if (fill_pos_ff == LAST_IDX) begin
                        refilling_in = 1'b0;
                        fill_pos_in  = '0;
                        count_in     = FULL_COUNT;
                     end else begin
                        fill_pos_in = fill_pos_ff + 1'b1;
                     end
                  end
               end
               gfbs_pkg::OP_ALLOC: begin
                  if (count_ff == '0) begin
                     status_in = gfbs_pkg::STATUS_EMPTY;
                  end else begin
                     given_in = rd_data_ff;
                     if ((count_ff == CNT_W'(1)) && (rd_data_ff != final_ff)) begin
                        count_in     = '0;
                        refilling_in = 1'b1;
                        fill_pos_in  = '0;
                        need_in      = 1'b1;
                     end else begin
                        count_in = count_dec;
                     end
                  end
               end
               gfbs_pkg::OP_RECLAIM: begin
                  if (count_ff == '0) begin
                     final_in = freed_ff;
                  end
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               gfbs_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
            endcase
         end
      end

      if (cmd.spill_start) begin
         spill_cnt_in = '0;
      end
      if (cmd.spill_next) begin
         spill_cnt_in = spill_cnt_ff + 1'b1;
      end
      if (cmd.spill_load) begin
         kind_in   = gfbs_pkg::KIND_SPILL;
         status_in = gfbs_pkg::STATUS_OK;
         given_in  = '0;
         need_in   = 1'b0;
         target_in = freed_ff;
         index_in  = gfbs_pkg::SPILL_IDX_W'(spill_cnt_ff);
         value_in  = rd_data_ff;
         last_in   = 1'b0;
      end
      if (cmd.spill_end) begin
         wr_en    = 1'b1;
         wr_addr  = '0;
         count_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem_ff[rd_addr];
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         freed_ff <= req_freed_block;
         word_ff  <= req_fill_word;
      end
      kind_ff   <= kind_in;
      status_ff <= status_in;
      given_ff  <= given_in;
      need_ff   <= need_in;
      target_ff <= target_in;
      index_ff  <= index_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         final_ff     <= '0;
         refilling_ff <= 1'b0;
         fill_pos_ff  <= '0;
         spill_cnt_ff <= '0;
      end else begin
         count_ff     <= count_in;
         final_ff     <= final_in;
         refilling_ff <= refilling_in;
         fill_pos_ff  <= fill_pos_in;
         spill_cnt_ff <= spill_cnt_in;
      end
   end

   assign rsp_kind         = kind_ff;
   assign rsp_status       = status_ff;
   assign rsp_given_block  = given_ff;
   assign rsp_need_refill  = need_ff;
   assign rsp_spill_target = target_ff;
   assign rsp_spill_index  = index_ff;
   assign rsp_spill_value  = value_ff;
   assign rsp_last         = last_ff;

endmodule

>>> hdl/gfbs_controller.sv
// Controller of the grouped free block stack: sequences accept, execute,
// spill and response transfers. Depends on gfbs_pkg.
module gfbs_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  gfbs_pkg::dp_status_type status,
   output gfbs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SPILL_RD,
      ST_SPILL_LD,
      ST_SPILL_OUT,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      cmd.execute     = (state_ff == ST_EXEC) && !status.spill_needed;
      cmd.spill_start = (state_ff == ST_EXEC) && status.spill_needed;
      cmd.spill_read  = (state_ff == ST_SPILL_RD) || (state_ff == ST_SPILL_LD) ||
                        (state_ff == ST_SPILL_OUT);
      cmd.spill_load  = (state_ff == ST_SPILL_LD);
      cmd.spill_next  = (state_ff == ST_SPILL_OUT) && !rsp_stall && !status.spill_last;
      cmd.spill_end   = (state_ff == ST_SPILL_OUT) && !rsp_stall && status.spill_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (status.spill_needed) begin
                  state_ff <= ST_SPILL_RD;
               end else begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_SPILL_RD: begin
               state_ff <= ST_SPILL_LD;
            end
            ST_SPILL_LD: begin
               state_ff     <= ST_SPILL_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_SPILL_OUT: begin
               if (!rsp_stall) begin
                  if (status.spill_last) begin
                     state_ff <= ST_RESP;
                  end else begin
                     state_ff     <= ST_SPILL_RD;
                     rsp_valid_ff <= 1'b0;
                  end
               end
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hdl/grouped_free_block_stack_top.sv
// Top level of the grouped free block stack.
// Instantiates gfbs_controller and gfbs_datapath; depends on gfbs_pkg.
//
// The request channel carries an operation (allocate, reclaim, fill word,
// clear) with a freed block number and a fill word. The response channel
// returns one operation response per request, marked last, preceded on a
// full-stack reclaim by STACK_DEPTH spill words (kind set, index 0 upward)
// that the caller writes into the reclaimed block.
// One request is handled at a time. A request transfer moves the controller
// into its execute state, where the operation runs on the registered read of
// the stack memory and its outcome is loaded into the result register, which
// drives the response outputs. A full-stack reclaim first passes each spill
// word through a read, a load and an output state, in that order.
// While the receiver stalls, the current result holds and no request is
// accepted. Synchronous reset empties the stack, clears the final block and
// the refill state and drops rsp_valid; the stack memory itself is not
// cleared, and no entry's value is used before it has been written.
module grouped_free_block_stack_top #(
   parameter int STACK_DEPTH = gfbs_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gfbs_pkg::OP_W-1:0]            req_operation,
   input  logic [gfbs_pkg::WORD_W-1:0]          req_freed_block,
   input  logic [gfbs_pkg::WORD_W-1:0]          req_fill_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_kind,
   output logic [gfbs_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_given_block,
   output logic                                 rsp_need_refill,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_spill_target,
   output logic [gfbs_pkg::SPILL_IDX_W-1:0]     rsp_spill_index,
   output logic [gfbs_pkg::WORD_W-1:0]          rsp_spill_value,
   output logic                                 rsp_last
);

   gfbs_pkg::ctrl_cmd_type  cmd;
   gfbs_pkg::dp_status_type status;

   gfbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gfbs_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_freed_block  (req_freed_block),
      .req_fill_word    (req_fill_word),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_given_block  (rsp_given_block),
      .rsp_need_refill  (rsp_need_refill),
      .rsp_spill_target (rsp_spill_target),
      .rsp_spill_index  (rsp_spill_index),
      .rsp_spill_value  (rsp_spill_value),
      .rsp_last         (rsp_last)
   );

   a_no_accept_with_result: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid
   ) else $error("request transfer while a result is pending");

   a_spill_not_last: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == gfbs_pkg::KIND_SPILL)) |-> !rsp_last
   ) else $error("spill word marked last");

   a_refill_only_on_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_need_refill) |->
         ((rsp_status == gfbs_pkg::STATUS_OK) && (rsp_kind == gfbs_pkg::KIND_RESPONSE))
   ) else $error("refill request on a failed or spill result");

   a_ready_after_last: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall
   ) else $error("request channel not ready after the final result transfer");

endmodule
